// ===== src/rpfa_pkg.sv =====
`timescale 1ns / 1ps

package rpfa_pkg;

    localparam int PAGE_W     = 10;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int LOW_W      = 10;
    localparam int HIGH_W     = 11;

    localparam logic [LOW_W-1:0]  LOW_RESET  = 10'd0;
    localparam logic [HIGH_W-1:0] HIGH_RESET = 11'd1024;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX       = 8'sd127;
    localparam logic signed [COUNT_W-1:0] COUNT_UNMANAGED = -8'sd1;
    localparam logic signed [COUNT_W-1:0] COUNT_ZERO      = 8'sd0;
    localparam logic signed [COUNT_W-1:0] COUNT_ONE       = 8'sd1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PAGE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PAGE = 1'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_PAGE = 3'd0,
        MODE_ALLOC    = 3'd1,
        MODE_SHARE    = 3'd2,
        MODE_RELEASE  = 3'd3,
        MODE_QUERY    = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOT_HELD = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

endpackage

// ===== src/rpfa_in_if.sv =====
`timescale 1ns / 1ps

interface rpfa_in_if;
    logic                          valid;
    logic                          ready;
    logic [rpfa_pkg::MODE_W-1:0]   mode;
    logic [rpfa_pkg::PAGE_W-1:0]   page_number;

    modport source (output valid, output mode, output page_number, input ready);
    modport sink   (input valid, input mode, input page_number, output ready);
endinterface

// ===== src/rpfa_out_if.sv =====
`timescale 1ns / 1ps

interface rpfa_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rpfa_pkg::STATUS_W-1:0]        status;
    logic [rpfa_pkg::PAGE_W-1:0]          result_page;
    logic signed [rpfa_pkg::COUNT_W-1:0]  ref_count;
    logic                                 page_freed;

    modport source (output valid, output status, output result_page, output ref_count,
                    output page_freed, input ready);
    modport sink   (input valid, input status, input result_page, input ref_count,
                    input page_freed, output ready);
endinterface

// ===== src/refcounted_page_frame_allocator.sv =====
`timescale 1ns / 1ps

// Reference-counted page frame allocator. Each transfer on i_in carries a mode (add_page,
// alloc, share, release, query; codes 5 to 7 act as query) and a page number, and gives
// exactly one result transfer on o_out with a status, the page, its count after the
// operation (-1 for unmanaged) and a flag that says the page went back onto the free list.
// Per-page counts live in one synchronous memory and the links of the last-in-first-out
// free list in a second one; the list head is a register. On acceptance both memories
// are read; in S_EXEC the count is modified, written back, the list pushed or popped and
// the output register loaded. i_in.ready is high only in S_IDLE, so no new item is taken
// while one is in S_EXEC, and an item waits in S_EXEC while a previous result is not taken.
// After reset a clearing pass sets every count to -1, one entry a cycle; no item is taken
// meanwhile, configuration writes are. Configuration registers (index 0 low_page, index 1
// high_page): the user writes them only while the block is idle; the block does not enforce it.
module refcounted_page_frame_allocator #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rpfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rpfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rpfa_in_if.sink                             i_in,
    rpfa_out_if.source                          o_out
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PAGES - 1);
    localparam int NXT_W = rpfa_pkg::PAGE_W + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // control state
    t_state                              r_state, n_state;
    logic [AW-1:0]                       r_clr_addr, n_clr_addr;
    logic [rpfa_pkg::PAGE_W-1:0]         r_head, n_head;
    logic                                r_nonempty, n_nonempty;
    logic                                r_out_valid, n_out_valid;
    logic [rpfa_pkg::LOW_W-1:0]          r_low_page;
    logic [rpfa_pkg::HIGH_W-1:0]         r_high_page;

    // item held between the read and the write-back cycle
    rpfa_pkg::t_mode                     r_mode, n_mode;
    logic [rpfa_pkg::PAGE_W-1:0]         r_page, n_page;
    logic                                r_in_range, n_in_range;

    // output register
    rpfa_pkg::t_status                   r_out_status, n_out_status;
    logic [rpfa_pkg::PAGE_W-1:0]         r_out_page, n_out_page;
    logic signed [rpfa_pkg::COUNT_W-1:0] r_out_count, n_out_count;
    logic                                r_out_freed, n_out_freed;

    // memory ports
    logic                                cnt_we, cnt_re;
    logic [AW-1:0]                       cnt_waddr, cnt_raddr;
    logic [rpfa_pkg::COUNT_W-1:0]        cnt_wdata, cnt_rdata;
    logic                                nxt_we;
    logic [AW-1:0]                       nxt_raddr;
    logic [NXT_W-1:0]                    nxt_wdata, nxt_rdata;

    logic                                in_xfer, out_xfer, slot_free, head_bad, push;
    logic signed [rpfa_pkg::COUNT_W-1:0] cur_count;
    logic                                range_now;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign out_xfer  = r_out_valid && o_out.ready;
    // result slot is free now or frees at this edge
    assign slot_free = !r_out_valid || o_out.ready;
    assign cur_count = $signed(cnt_rdata);
    assign head_bad  = 32'(r_head) >= 32'(NUM_PAGES);

    // bounds check at acceptance; the user keeps config stable while an item is in flight, not enforced here
    assign range_now = (i_in.page_number >= r_low_page)
                    && ({1'b0, i_in.page_number} < r_high_page)
                    && (32'(i_in.page_number) < 32'(NUM_PAGES));

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.result_page = r_out_page;
    assign o_out.ref_count   = r_out_count;
    assign o_out.page_freed  = r_out_freed;

    // reads are issued with the input transfer, alloc reads the count at the head
    assign cnt_re    = in_xfer;
    assign cnt_raddr = (rpfa_pkg::t_mode'(i_in.mode) == rpfa_pkg::MODE_ALLOC)
                       ? AW'(r_head) : AW'(i_in.page_number);
    assign nxt_raddr = AW'(r_head);

    // link written on every push: old head and whether the list was nonempty
    assign nxt_wdata = {r_nonempty, r_head};

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_head       = r_head;
        n_nonempty   = r_nonempty;
        n_out_valid  = r_out_valid;
        n_mode       = r_mode;
        n_page       = r_page;
        n_in_range   = r_in_range;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_count  = r_out_count;
        n_out_freed  = r_out_freed;
        cnt_we       = 1'b0;
        cnt_waddr    = AW'(r_page);
        cnt_wdata    = rpfa_pkg::COUNT_ZERO;
        nxt_we       = 1'b0;
        push         = 1'b0;

        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // sweep every count entry to unmanaged
                cnt_we     = 1'b1;
                cnt_waddr  = r_clr_addr;
                cnt_wdata  = rpfa_pkg::COUNT_UNMANAGED;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_mode     = rpfa_pkg::t_mode'(i_in.mode);
                    n_page     = i_in.page_number;
                    n_in_range = range_now;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_freed  = 1'b0;
                    n_out_page   = r_page;
                    if (r_mode == rpfa_pkg::MODE_ALLOC) begin
                        if (!r_nonempty || head_bad) begin
                            n_out_status = rpfa_pkg::ST_EMPTY;
                            n_out_page   = '0;
                            n_out_count  = rpfa_pkg::COUNT_ZERO;
                        end else if (cur_count >= rpfa_pkg::COUNT_MAX) begin
                            // page stays at the head
                            n_out_status = rpfa_pkg::ST_OVERFLOW;
                            n_out_page   = r_head;
                            n_out_count  = cur_count;
                        end else begin
                            // pop the head
                            cnt_we       = 1'b1;
                            cnt_waddr    = AW'(r_head);
                            cnt_wdata    = cur_count + rpfa_pkg::COUNT_ONE;
                            n_head       = nxt_rdata[rpfa_pkg::PAGE_W-1:0];
                            n_nonempty   = nxt_rdata[NXT_W-1];
                            n_out_status = rpfa_pkg::ST_OK;
                            n_out_page   = r_head;
                            n_out_count  = cur_count + rpfa_pkg::COUNT_ONE;
                        end
                    end else if (!r_in_range) begin
                        n_out_status = rpfa_pkg::ST_RANGE;
                        n_out_count  = rpfa_pkg::COUNT_UNMANAGED;
                    end else begin
                        case (r_mode)
                            rpfa_pkg::MODE_ADD_PAGE: begin
                                // no check for a page already on the list
                                cnt_we       = 1'b1;
                                cnt_wdata    = rpfa_pkg::COUNT_ZERO;
                                push         = 1'b1;
                                n_out_status = rpfa_pkg::ST_OK;
                                n_out_count  = rpfa_pkg::COUNT_ZERO;
                                n_out_freed  = 1'b1;
                            end
                            rpfa_pkg::MODE_SHARE: begin
                                if (cur_count >= rpfa_pkg::COUNT_MAX) begin
                                    n_out_status = rpfa_pkg::ST_OVERFLOW;
                                    n_out_count  = cur_count;
                                end else begin
                                    cnt_we       = 1'b1;
                                    cnt_wdata    = cur_count + rpfa_pkg::COUNT_ONE;
                                    n_out_status = rpfa_pkg::ST_OK;
                                    n_out_count  = cur_count + rpfa_pkg::COUNT_ONE;
                                end
                            end
                            rpfa_pkg::MODE_RELEASE: begin
                                if (cur_count <= rpfa_pkg::COUNT_ZERO) begin
                                    n_out_status = rpfa_pkg::ST_NOT_HELD;
                                    n_out_count  = cur_count;
                                end else begin
                                    cnt_we       = 1'b1;
                                    cnt_wdata    = cur_count - rpfa_pkg::COUNT_ONE;
                                    n_out_status = rpfa_pkg::ST_OK;
                                    n_out_count  = cur_count - rpfa_pkg::COUNT_ONE;
                                    // last reference dropped, page goes back on the list
                                    if (cur_count == rpfa_pkg::COUNT_ONE) begin
                                        push        = 1'b1;
                                        n_out_freed = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                // query and the unused codes
                                n_out_status = rpfa_pkg::ST_OK;
                                n_out_count  = cur_count;
                            end
                        endcase
                    end
                    if (push) begin
                        nxt_we     = 1'b1;
                        n_head     = r_page;
                        n_nonempty = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_out_valid <= 1'b0;
            r_low_page  <= rpfa_pkg::LOW_RESET;
            r_high_page <= rpfa_pkg::HIGH_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_head      <= n_head;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rpfa_pkg::CFG_LOW_PAGE: begin
                        r_low_page <= i_cfg_data[rpfa_pkg::LOW_W-1:0];
                    end
                    rpfa_pkg::CFG_HIGH_PAGE: begin
                        r_high_page <= i_cfg_data[rpfa_pkg::HIGH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_mode       <= n_mode;
        r_page       <= n_page;
        r_in_range   <= n_in_range;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_count  <= n_out_count;
        r_out_freed  <= n_out_freed;
    end

    // per-page reference counts
    rpfa_ram #(
        .WIDTH (rpfa_pkg::COUNT_W),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // free-list links: {link valid, next page}
    rpfa_ram #(
        .WIDTH (NXT_W),
        .DEPTH (NUM_PAGES)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (AW'(r_page)),
        .i_wdata (nxt_wdata),
        .i_re    (cnt_re),
        .i_raddr (nxt_raddr),
        .o_rdata (nxt_rdata)
    );

    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input taken during clearing pass");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (!i_in.ready && r_state == S_EXEC))
        else $error("second item taken before write-back");

    a_push_sets_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && slot_free && push) |=> (r_nonempty && r_head == $past(r_page)))
        else $error("push did not update the list head");

    a_freed_is_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_freed) |->
            (r_out_status == rpfa_pkg::ST_OK && r_out_count == rpfa_pkg::COUNT_ZERO))
        else $error("freed page reported with nonzero count or error");

endmodule

// ===== src/rpfa_ram.sv =====
`timescale 1ns / 1ps

module rpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
